### hdl/pcf_pkg.sv
// Package for the ping-pong capture framer: sizes, sync bytes, event kinds
// and sequencer state type. No dependencies.
`default_nettype none
package pcf_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned SLOTS_DEF    = 8;
  localparam int unsigned SAMPLE_W     = 24;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned CHAN_W       = 2;
  localparam int unsigned IN_DATA_W    = 40;

  localparam logic [7:0] SYNC0     = 8'h55;
  localparam logic [7:0] SYNC1     = 8'hAA;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_INDEX   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYNC,
    ST_READ,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_TAIL
  } state_t;

endpackage
`default_nettype wire

### hdl/pingpong_capture_framer.sv
// Top level of the ping-pong capture framer: event handling, sample store
// and frame sequencer. Depends on pcf_pkg and pcf_ram.
//
// Capture events (tuser = 0) store bits 23:0 of the timer value for their
// channel at the current slot of the active bank; index pulses (tuser = 1)
// advance the slot, and on wrap to zero the banks swap and the bank just
// filled goes out as a frame: 0x55 0xAA, then each channel's samples in slot
// order, three bytes each, LSB first, two bytes per 16-bit word (earlier
// byte low). An odd final byte is padded with zero. tlast marks the final
// word. Events are ignored while capture_enable is low. Capture and
// non-wrapping index transactions leave the input ready. A wrapping index
// pulse starts a frame of 1 + ceil(3*CHANNELS*SLOTS/2) words (49 by
// default); the input is not ready until the last word is loaded into the
// output register. The sequencer reads the sample RAM one entry at a time
// through its single read port and packs the bytes two to a word; output
// stalls hold it. The store reads as zero after reset via one valid flag
// per entry, so no clearing pass is needed.
`default_nettype none
module pingpong_capture_framer #(
  parameter int unsigned CHANNELS = pcf_pkg::CHANNELS_DEF,
  parameter int unsigned SLOTS    = pcf_pkg::SLOTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration
  input  wire logic                               cfg_wen,
  input  wire logic                               cfg_wdata,   // capture_enable
  // event stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [pcf_pkg::IN_DATA_W-1:0]      s_tdata,     // [1:0] channel,
                                                               // [33:2] capture_value
  input  wire logic                               s_tuser,     // kind
  // frame stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [pcf_pkg::WORD_W-1:0]              m_tdata,     // [15:0] frame_word
  output logic                                    m_tlast      // last_word
);
  import pcf_pkg::*;

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SL_W   = $clog2(SLOTS);
  localparam int unsigned ADDR_W = 1 + CH_W + SL_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  // Registers
  logic                capture_enable;
  logic [SL_W-1:0]     slot_index;
  logic                active_bank;
  logic                frame_bank;
  logic [CH_W-1:0]     ch_cnt;
  logic [SL_W-1:0]     sl_cnt;
  logic                pend;
  logic [7:0]          pend_byte;
  logic [DEPTH-1:0]    valid;
  logic                valid_q;
  state_t              state, state_next;

  // Input fields
  logic                kind;
  logic [CHAN_W-1:0]   channel;
  logic [VALUE_W-1:0]  capture_value;

  assign kind          = s_tuser;
  assign channel       = s_tdata[CHAN_W-1:0];
  assign capture_value = s_tdata[CHAN_W +: VALUE_W];

  // Sequencer controls
  logic                in_take;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] sample;
  logic                out_free;
  logic                load;
  logic [WORD_W-1:0]   word_d;
  logic                last_d;
  logic                advance;
  logic                pend_set;
  logic                pend_clr;
  logic                last_sample;
  logic                slot_wrap;
  logic [SL_W-1:0]     slot_next;

  assign s_tready  = (state == ST_IDLE);
  assign in_take   = s_tvalid && s_tready && capture_enable;
  assign out_free  = !m_tvalid || m_tready;
  assign slot_wrap = (slot_index == SL_W'(SLOTS - 1));
  assign slot_next = slot_wrap ? '0 : slot_index + SL_W'(1);

  assign wr_en   = in_take && (kind == KIND_CAPTURE) && (32'(channel) < CHANNELS);
  assign wr_addr = {active_bank, channel[CH_W-1:0], slot_index};
  assign rd_addr = {frame_bank, ch_cnt, sl_cnt};

  // unwritten entries read as zero
  assign sample      = valid_q ? rd_data : '0;
  assign last_sample = (ch_cnt == CH_W'(CHANNELS - 1)) && (sl_cnt == SL_W'(SLOTS - 1));

  pcf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (capture_value[SAMPLE_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and byte packing
  always_comb begin
    state_next = state;
    load       = 1'b0;
    word_d     = '0;
    last_d     = 1'b0;
    rd_en      = 1'b0;
    advance    = 1'b0;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_take && (kind == KIND_INDEX) && slot_wrap) begin
          state_next = ST_SYNC;
        end
      end
      ST_SYNC: begin
        if (out_free) begin
          load       = 1'b1;
          word_d     = {SYNC1, SYNC0};
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_EMIT_A;
      end
      ST_EMIT_A: begin
        if (out_free) begin
          load = 1'b1;
          if (!pend) begin
            word_d   = sample[15:0];
            pend_set = 1'b1;
            if (last_sample) begin
              state_next = ST_TAIL;
            end else begin
              advance    = 1'b1;
              state_next = ST_READ;
            end
          end else begin
            word_d     = {sample[7:0], pend_byte};
            state_next = ST_EMIT_B;
          end
        end
      end
      ST_EMIT_B: begin
        if (out_free) begin
          load     = 1'b1;
          word_d   = sample[23:8];
          last_d   = last_sample;
          pend_clr = 1'b1;
          if (last_sample) begin
            state_next = ST_IDLE;
          end else begin
            advance    = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          load       = 1'b1;
          word_d     = {BYTE_ZERO, pend_byte};
          last_d     = 1'b1;
          pend_clr   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
      slot_index     <= '0;
      active_bank    <= 1'b0;
      frame_bank     <= 1'b0;
      ch_cnt         <= '0;
      sl_cnt         <= '0;
      pend           <= 1'b0;
      valid          <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        capture_enable <= cfg_wdata;
      end
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (in_take && (kind == KIND_INDEX)) begin
        slot_index <= slot_next;
        if (slot_wrap) begin
          frame_bank  <= active_bank;
          active_bank <= ~active_bank;
          ch_cnt      <= '0;
          sl_cnt      <= '0;
        end
      end
      if (advance) begin
        if (sl_cnt == SL_W'(SLOTS - 1)) begin
          sl_cnt <= '0;
          ch_cnt <= ch_cnt + CH_W'(1);
        end else begin
          sl_cnt <= sl_cnt + SL_W'(1);
        end
      end
      if (pend_set) begin
        pend <= 1'b1;
      end else if (pend_clr) begin
        pend <= 1'b0;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      valid_q <= valid[rd_addr];
    end
    if (pend_set) begin
      pend_byte <= sample[23:16];
    end
    if (load) begin
      m_tdata <= word_d;
      m_tlast <= last_d;
    end
  end

  // Checks
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_IDLE))
    else $error("store written during frame read-out");

  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend)
    else $error("pending byte left over at end of frame");

  a_pend_needed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_B || state == ST_TAIL) |-> pend)
    else $error("odd byte missing when packing second word");

  a_frame_on_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SYNC && $past(state) == ST_IDLE) |->
      (slot_index == '0 && active_bank != frame_bank))
    else $error("frame started without a bank swap");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("output word overwritten before transfer");

endmodule
`default_nettype wire

### hdl/pcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Uses pcf_pkg for its default width only.
`default_nettype none
module pcf_ram #(
  parameter int unsigned WIDTH  = pcf_pkg::SAMPLE_W,
  parameter int unsigned DEPTH  = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);
  import pcf_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### tb/pingpong_capture_framer_tb.sv
// Self-checking bench for pingpong_capture_framer: drives capture and index
// transactions, mirrors the two-bank sample store and checks every frame word.
// Depends on pcf_pkg and the pingpong_capture_framer RTL.
module pingpong_capture_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcf_pkg::*;

  localparam int unsigned CH          = CHANNELS_DEF;
  localparam int unsigned SL          = SLOTS_DEF;
  // sync pair plus three bytes per sample, packed two bytes to a word
  localparam int unsigned FRAME_BYTES = 2 + 3 * CH * SL;
  // store reads as zero after reset; a short settle covers any capture or
  // index transaction still in flight
  localparam int unsigned IDLE_SETTLE    = 8;
  // wait past the read-out of the last frame at the end
  localparam int unsigned DRAIN_TAIL     = 120;
  // worst quiet spell: sender gaps or receiver stalls plus a frame read-out
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_EVENTS  = 425;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [WORD_W-1:0] frame_word;
    logic              last_word;
  } frame_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic                 cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata;   // [1:0] channel, [33:2] capture_value
  logic                 s_tuser;   // kind
  logic                 m_tvalid;
  logic                 m_tready;
  logic [WORD_W-1:0]    m_tdata;   // [15:0] frame_word
  logic                 m_tlast;   // last_word

  // mirror of the block's state
  logic [SAMPLE_W-1:0] sample_mirror [0:1][0:CH-1][0:SL-1];
  int unsigned         slot_now;
  bit                  bank_now;
  bit                  capture_on;

  frame_beat_t expected_beats [$];
  int unsigned mismatches;
  int unsigned live_events;     // transactions accepted while capture is enabled
  int unsigned tx_quiet_left;   // sender transactions left with no gap
  int unsigned rx_quiet_left;   // frame words left with no stall
  int unsigned quiet_cycles;

  pingpong_capture_framer #(
    .CHANNELS(CH),
    .SLOTS   (SL)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame predictor: while capture is on, updates the mirror on each accepted
  // transaction and queues 49 frame words when an index pulse wraps the slot.
  // ---------------------------------------------------------------------------
  task automatic predict_event(input logic kind, input logic [CHAN_W-1:0] ch,
                               input logic [VALUE_W-1:0] value);
    logic [7:0]          frame_bytes [0:FRAME_BYTES];
    logic [SAMPLE_W-1:0] sample;
    frame_beat_t         beat;
    int unsigned         n;
    bit                  filled;
    if (!capture_on) return;
    if (kind == KIND_CAPTURE) begin
      if (ch < CH) sample_mirror[bank_now][ch][slot_now] = value[SAMPLE_W-1:0];
      return;
    end
    slot_now = (slot_now + 1) % SL;
    if (slot_now != 0) return;
    // wrap: swap banks, the bank just filled goes out
    filled   = bank_now;
    bank_now = ~bank_now;
    frame_bytes[0] = SYNC0;
    frame_bytes[1] = SYNC1;
    n = 2;
    for (int c = 0; c < CH; c++) begin
      for (int s = 0; s < SL; s++) begin
        sample             = sample_mirror[filled][c][s];
        frame_bytes[n]     = sample[7:0];
        frame_bytes[n + 1] = sample[15:8];
        frame_bytes[n + 2] = sample[23:16];
        n = n + 3;
      end
    end
    // pad byte for an odd byte count
    frame_bytes[FRAME_BYTES] = BYTE_ZERO;
    for (int k = 0; k < FRAME_BYTES; k += 2) begin
      beat.frame_word = {frame_bytes[k + 1], frame_bytes[k]};
      beat.last_word  = (k + 2 >= FRAME_BYTES);
      expected_beats.push_back(beat);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic check_beat(input logic [WORD_W-1:0] word, input logic last);
    frame_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected frame word %h last %b", word, last));
      return;
    end
    want = expected_beats.pop_front();
    if (word !== want.frame_word)
      report_mismatch($sformatf("frame_word expected %h actual %h",
                                want.frame_word, word));
    if (last !== want.last_word)
      report_mismatch($sformatf("last_word expected %b actual %b (word %h)",
                                want.last_word, last, word));
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one transaction per call. Entered and left at a falling edge;
  // tvalid is left high so back-to-back transactions need no second write.
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic kind, input logic [CHAN_W-1:0] ch,
                            input logic [VALUE_W-1:0] value);
    int unsigned gap;
    if (tx_quiet_left > 0) begin
      gap = 0;
      tx_quiet_left--;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 15) == 0) tx_quiet_left = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {{(IN_DATA_W - VALUE_W - CHAN_W){1'b0}}, value, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (capture_on) live_events++;
    predict_event(kind, ch, value);
    @(negedge clk);
  endtask

  // sender holds off until every queued frame word has come out
  task automatic hold_until_drained;
    s_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  // config is only touched once the block is quiet
  task automatic set_capture_enable(input bit on);
    hold_until_drained();
    repeat (IDLE_SETTLE) @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_wdata = on;
    @(posedge clk);
    capture_on = on;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Paused: neither a capture nor index pulses may move the slot or the store.
  task automatic test_ignored_while_paused;
    set_capture_enable(1'b0);
    send_event(KIND_CAPTURE, 2'd3, 32'hFFFF_FFFF);
    repeat (3) send_event(KIND_INDEX, $urandom_range(0, 3), $urandom);
  endtask

  // Extreme sample values on every channel; timer bits 31:24 must be dropped.
  // First wrap after reset, so unwritten entries come out as zero.
  task automatic test_field_extremes;
    set_capture_enable(1'b1);
    send_event(KIND_CAPTURE, 2'd0, 32'hFFFF_FFFF);
    send_event(KIND_CAPTURE, 2'd1, 32'h0000_0000);
    send_event(KIND_CAPTURE, 2'd2, 32'hFF00_0000);
    send_event(KIND_CAPTURE, 2'd3, 32'h5AA5_C33C);
    repeat (SL) send_event(KIND_INDEX, $urandom_range(0, 3), $urandom);
    hold_until_drained();
  endtask

  // Pause part-way through a frame: ignored events in between, wrap still
  // comes after exactly SLOTS live index pulses.
  task automatic test_pause_mid_frame;
    send_event(KIND_CAPTURE, 2'd1, 32'h0012_3456);
    repeat (2) send_event(KIND_INDEX, 2'd0, $urandom);
    set_capture_enable(1'b0);
    send_event(KIND_INDEX, 2'd2, $urandom);
    send_event(KIND_CAPTURE, 2'd1, 32'hFFFF_FFFF);
    set_capture_enable(1'b1);
    repeat (SL - 2) send_event(KIND_INDEX, 2'd3, $urandom);
  endtask

  // Mostly well-formed frames (a few captures per slot, then an index pulse),
  // mixed with random-kind noise and paused stretches.
  task automatic test_random_frames;
    live_events = 0;
    while (live_events < RANDOM_EVENTS) begin
      case ($urandom_range(0, 7))
        0: begin
          repeat (8)
            send_event($urandom_range(0, 1), $urandom_range(0, 3), $urandom);
        end
        1: begin
          set_capture_enable(1'b0);
          repeat ($urandom_range(1, 4))
            send_event($urandom_range(0, 1), $urandom_range(0, 3), $urandom);
          set_capture_enable(1'b1);
        end
        default: begin
          for (int s = 0; s < SL; s++) begin
            repeat ($urandom_range(0, 3))
              send_event(KIND_CAPTURE, $urandom_range(0, 3), $urandom);
            send_event(KIND_INDEX, $urandom_range(0, 3), $urandom);
          end
        end
      endcase
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Frame receiver and checker: random stall before each word, with runs of
  // back-to-back words now and then.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_quiet_left > 0) begin
        stall = 0;
        rx_quiet_left--;
      end else begin
        stall = $urandom_range(0, 15);
        if ($urandom_range(0, 15) == 0) rx_quiet_left = $urandom_range(10, 60);
      end
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      check_beat(m_tdata, m_tlast);
      @(negedge clk);
    end
  end

  // Watchdog: ends the run after a long spell with no transaction on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("pingpong_capture_framer verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_wdata     = 1'b0;
    s_tvalid      = 1'b0;
    s_tuser       = KIND_CAPTURE;
    s_tdata       = '0;
    mismatches    = 0;
    live_events   = 0;
    tx_quiet_left = 0;
    rx_quiet_left = 0;
    quiet_cycles  = 0;
    slot_now      = 0;
    bank_now      = 1'b0;
    capture_on    = 1'b0;
    for (int b = 0; b < 2; b++)
      for (int c = 0; c < CH; c++)
        for (int s = 0; s < SL; s++) sample_mirror[b][c][s] = '0;

    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_ignored_while_paused();
    test_field_extremes();
    test_pause_mid_frame();
    test_random_frames();

    hold_until_drained();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (mismatches == 0) begin
      $display("pingpong_capture_framer verification clean");
    end else begin
      $display("pingpong_capture_framer verification failed");
    end
    $finish;
  end

endmodule
